// ===== rtl/core/sqfu_pkg.sv =====
// Shared types and constants for the symmetric quadratic form update unit.
package sqfu_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_INNER   = 8;
  localparam int IDX_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 104;
  localparam int CFG_IDX_W   = 2;
  localparam int Z_DEPTH     = MAX_INNER * MAX_ROWS;
  localparam int T_DEPTH     = MAX_INNER * MAX_INNER;
  localparam int A_DEPTH     = MAX_ROWS * MAX_ROWS;

  typedef enum logic [1:0] {
    FUNC_LOAD_Z  = 2'd0,
    FUNC_LOAD_T  = 2'd1,
    FUNC_LOAD_A  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_IN_USE  = 2'd0,
    CFG_INNER_IN_USE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

endpackage

// ===== rtl/core/symmetric_quadratic_form_update_unit.sv =====
// Top level: E = A - Z^T T Z over three element stores, emitted row-major.
// Load items never raise busy, so loads stream back to back.
// A compute item holds busy until the last element of E is output. The issue counter
// walks one triple product a cycle through the store read ports, and each element
// of E passes stages 1-4, accumulator and output, on result_valid for one cycle.
// rst (synchronous) clears control and sets both sizes to 8; stores keep junk.
// Results cannot be stalled by the receiver.
module symmetric_quadratic_form_update_unit
  import sqfu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in,
  output logic                 result_valid,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  // Token that travels with each triple product down the pipe.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             fin;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tok_t;

  logic [VAL_W-1:0] z_mem [Z_DEPTH];
  logic [VAL_W-1:0] t_mem [T_DEPTH];
  logic [VAL_W-1:0] a_mem [A_DEPTH];

  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] inner_in_use;
  logic [SIZE_W-1:0] nz;
  logic [SIZE_W-1:0] nt;

  logic             issuing;
  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] cj;
  logic [IDX_W-1:0] cx;
  logic [IDX_W-1:0] cy;
  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] hi_idx;
  logic             y_end;
  logic             x_end;
  logic             j_end;
  logic             i_end;
  tok_t             tok0;

  tok_t                    tok1;
  tok_t                    tok2;
  tok_t                    tok3;
  tok_t                    tok4;
  logic signed [VAL_W-1:0] za1;
  logic signed [VAL_W-1:0] zb1;
  logic signed [VAL_W-1:0] t1;
  logic signed [VAL_W-1:0] a1;
  logic signed [63:0]      p2;
  logic signed [VAL_W-1:0] t2;
  logic signed [VAL_W-1:0] a2;
  logic signed [64:0]      qlo3;
  logic signed [63:0]      qhi3;
  logic signed [VAL_W-1:0] a3;
  logic signed [ACC_W-1:0] tri4;
  logic signed [VAL_W-1:0] a4;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_base;
  logic                    done;
  logic                    done_fin;
  logic [IDX_W-1:0]        done_row;
  logic [IDX_W-1:0]        done_col;
  logic signed [VAL_W-1:0] sat_value;

  logic accept;
  logic accept_load;

  assign cfg_ready   = 1'b1;
  assign accept      = start && !busy;
  assign accept_load = accept && (in.func != FUNC_COMPUTE);

  // Clamp sizes: zero counts as one, anything past the store maximum as the maximum.
  always_comb begin
    if (rows_in_use == '0) begin
      nz = SIZE_W'(1);
    end else if (rows_in_use > SIZE_W'(MAX_ROWS)) begin
      nz = SIZE_W'(MAX_ROWS);
    end else begin
      nz = rows_in_use;
    end
    if (inner_in_use == '0) begin
      nt = SIZE_W'(1);
    end else if (inner_in_use > SIZE_W'(MAX_INNER)) begin
      nt = SIZE_W'(MAX_INNER);
    end else begin
      nt = inner_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= SIZE_W'(MAX_ROWS);
      inner_in_use <= SIZE_W'(MAX_INNER);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_IN_USE:  rows_in_use  <= cfg_data;
        CFG_INNER_IN_USE: inner_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stores: one write port for loads, read ports driven by the issue counters.
  // Loads only happen while idle, so reads never race a write to the same entry.
  always_ff @(posedge clk) begin
    if (accept_load) begin
      case (in.func)
        FUNC_LOAD_Z: z_mem[{in.row_index, in.col_index}] <= in.element_value;
        FUNC_LOAD_T: t_mem[{in.row_index, in.col_index}] <= in.element_value;
        FUNC_LOAD_A: a_mem[{in.row_index, in.col_index}] <= in.element_value;
        default: ;
      endcase
    end
  end

  // Upper-triangle coordinates: the lower triangle mirrors the upper one.
  assign lo_idx = (ci <= cj) ? ci : cj;
  assign hi_idx = (ci <= cj) ? cj : ci;

  assign y_end = ({1'b0, cy} == nt - SIZE_W'(1));
  assign x_end = ({1'b0, cx} == nt - SIZE_W'(1));
  assign j_end = ({1'b0, cj} == nz - SIZE_W'(1));
  assign i_end = ({1'b0, ci} == nz - SIZE_W'(1));

  always_comb begin
    tok0.valid = issuing;
    tok0.first = (cx == '0) && (cy == '0);
    tok0.last  = x_end && y_end;
    tok0.fin   = i_end && j_end;
    tok0.row   = ci;
    tok0.col   = cj;
  end

  // Issue counters: y innermost, then x, then column, then row.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      ci      <= '0;
      cj      <= '0;
      cx      <= '0;
      cy      <= '0;
    end else if (accept && (in.func == FUNC_COMPUTE)) begin
      issuing <= 1'b1;
      ci      <= '0;
      cj      <= '0;
      cx      <= '0;
      cy      <= '0;
    end else if (issuing) begin
      if (!y_end) begin
        cy <= cy + IDX_W'(1);
      end else begin
        cy <= '0;
        if (!x_end) begin
          cx <= cx + IDX_W'(1);
        end else begin
          cx <= '0;
          if (!j_end) begin
            cj <= cj + IDX_W'(1);
          end else begin
            cj <= '0;
            if (!i_end) begin
              ci <= ci + IDX_W'(1);
            end else begin
              issuing <= 1'b0;
            end
          end
        end
      end
    end
  end

  // Stage 1: registered store reads.
  always_ff @(posedge clk) begin
    za1 <= z_mem[{cx, lo_idx}];
    zb1 <= z_mem[{cy, hi_idx}];
    t1  <= t_mem[{cx, cy}];
    a1  <= a_mem[{lo_idx, hi_idx}];
  end

  // Stage 2: Z*Z. Stage 3: split product times T. Stage 4: recombine.
  always_ff @(posedge clk) begin
    p2   <= za1 * zb1;
    t2   <= t1;
    a2   <= a1;
    qlo3 <= $signed({1'b0, p2[31:0]}) * t2;
    qhi3 <= $signed(p2[63:32]) * t2;
    a3   <= a2;
    tri4 <= (ACC_W'(qhi3) <<< 32) + ACC_W'(qlo3);
    a4   <= a3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1 <= '0;
      tok2 <= '0;
      tok3 <= '0;
      tok4 <= '0;
    end else begin
      tok1 <= tok0;
      tok2 <= tok1;
      tok3 <= tok2;
      tok4 <= tok3;
    end
  end

  // Accumulate: the first triple of an element seeds the sum with A scaled by 2^32.
  assign acc_base = tok4.first ? (ACC_W'(a4) <<< 32) : acc;

  always_ff @(posedge clk) begin
    if (tok4.valid) begin
      acc <= acc_base - tri4;
    end
    done_row <= tok4.row;
    done_col <= tok4.col;
    done_fin <= tok4.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tok4.valid && tok4.last;
    end
  end

  // Drop the Q32 fraction bits and saturate to 32 bits.
  always_comb begin
    if (acc[ACC_W-1:63] == '0 || acc[ACC_W-1:63] == '1) begin
      sat_value = acc[63:32];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      busy         <= 1'b0;
    end else begin
      result_valid <= done;
      if (accept && (in.func == FUNC_COMPUTE)) begin
        busy <= 1'b1;
      end else if (done && done_fin) begin
        busy <= 1'b0;
      end
    end
    result.out_row   <= done_row;
    result.out_col   <= done_col;
    result.out_value <= sat_value;
    result.last      <= done_fin;
  end

endmodule
